FILE: hw/rtl/csw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csw_pkg
// Shared types and constants of the counting semaphore with its wait queue.
// ----------------------------------------------------------------------------
package csw_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int ID_W     = 8;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = 16;
    localparam int COUNT_W  = 18;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    // Default sizes handed down from the top level
    localparam int DEF_MAX_WAITERS = 16;
    localparam int DEF_THREAD_BITS = 8;

    // Saturation limits of the signed count
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 18'sh1FFFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 18'sh20000;

    // Operation codes carried in the input tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_WAIT    = 2'd0,
        MODE_SIGNAL  = 2'd1,
        MODE_RELEASE = 2'd2
    } t_mode;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    // Queue control from the semaphore sequencer to the cell chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

endpackage
`default_nettype wire

FILE: hw/rtl/counting_semaphore_wait_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit
// Counting semaphore with a first-in first-out queue of blocked threads.
// ----------------------------------------------------------------------------
// A result is registered and on the master side in the cycle after its
// transaction. Wait and signal give a single result each; release-all gives
// one queued waiter per cycle while the output slot is free (at least one
// result), set by the single pop per cycle at the head of the cell chain.
// Reset: clears the count, queue occupancy, sequencer and output valid;
// the waiter cells are not cleared.
module counting_semaphore_wait_queue_unit #(
    parameter int MAX_WAITERS = csw_pkg::DEF_MAX_WAITERS,
    parameter int THREAD_BITS = csw_pkg::DEF_THREAD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration: initial_count
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [csw_pkg::CFG_W-1:0]    i_cfg_wr_data,
    // input stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [csw_pkg::S_DATA_W-1:0] s_axis_tdata,  // [7:0] thread_id
    input  wire logic [csw_pkg::MODE_W-1:0]   s_axis_tuser,  // [1:0] mode
    // output stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [0] must_block, [8:1] woken_thread, [9] queue_overflow,
    // [10] count_saturated, [15:11] zero
    output logic [csw_pkg::M_DATA_W-1:0]      m_axis_tdata,
    output logic                              m_axis_tuser,  // [0] woken_valid
    output logic                              m_axis_tlast
);
    import csw_pkg::*;

    localparam int TW    = (THREAD_BITS < ID_W) ? THREAD_BITS : ID_W;
    localparam int OCC_W = $clog2(MAX_WAITERS + 1);

    t_state                    r_state, n_state;
    logic signed [COUNT_W-1:0] r_count, n_count;
    logic signed [COUNT_W-1:0] w_dec, w_inc;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_block, n_out_block;
    logic                      r_out_wvalid, n_out_wvalid;
    logic [ID_W-1:0]           r_out_wthread, n_out_wthread;
    logic                      r_out_ovf, n_out_ovf;
    logic                      r_out_sat, n_out_sat;
    logic                      r_out_last, n_out_last;
    logic                      w_out_free;
    logic                      w_accept;
    t_mode                     w_mode;
    t_q_ctrl                   w_qctrl;
    logic [TW-1:0]             w_head_id;
    logic [OCC_W-1:0]          w_occ;
    logic                      w_full;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mode        = t_mode'(s_axis_tuser);
    assign w_dec         = r_count - 18'sd1;
    assign w_inc         = r_count + 18'sd1;
    assign w_full        = (w_occ == OCC_W'(MAX_WAITERS));

    csw_queue #(
        .MAX_WAITERS (MAX_WAITERS),
        .ID_BITS     (TW),
        .OCC_W       (OCC_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_qctrl),
        .i_push_id (s_axis_tdata[TW-1:0]),
        .o_head_id (w_head_id),
        .o_occ     (w_occ)
    );

    // Sequence operations, update the count and build the next result
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        w_qctrl       = '0;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_block   = r_out_block;
        n_out_wvalid  = r_out_wvalid;
        n_out_wthread = r_out_wthread;
        n_out_ovf     = r_out_ovf;
        n_out_sat     = r_out_sat;
        n_out_last    = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid   = 1'b1;
                    n_out_block   = 1'b0;
                    n_out_wvalid  = 1'b0;
                    n_out_wthread = '0;
                    n_out_ovf     = 1'b0;
                    n_out_sat     = 1'b0;
                    n_out_last    = 1'b1;
                    case (w_mode)
                        MODE_WAIT: begin
                            // hold the count at its minimum
                            if (r_count == COUNT_MIN) begin
                                if (w_full) begin
                                    n_out_ovf = 1'b1;
                                end else begin
                                    w_qctrl.push = 1'b1;
                                    n_out_block  = 1'b1;
                                end
                            end else if (w_dec[COUNT_W-1]) begin
                                if (w_full) begin
                                    n_out_ovf = 1'b1;
                                end else begin
                                    n_count      = w_dec;
                                    w_qctrl.push = 1'b1;
                                    n_out_block  = 1'b1;
                                end
                            end else begin
                                n_count = w_dec;
                            end
                        end
                        MODE_SIGNAL: begin
                            if (r_count == COUNT_MAX) begin
                                n_out_sat = 1'b1;
                            end else begin
                                n_count = w_inc;
                                if ((w_inc[COUNT_W-1] || w_inc == '0) && w_occ != '0) begin
                                    w_qctrl.pop   = 1'b1;
                                    n_out_wvalid  = 1'b1;
                                    n_out_wthread = ID_W'(w_head_id);
                                end
                            end
                        end
                        MODE_RELEASE: begin
                            // emit the first waiter now, drain the rest after
                            if (w_occ != '0) begin
                                w_qctrl.pop   = 1'b1;
                                n_out_wvalid  = 1'b1;
                                n_out_wthread = ID_W'(w_head_id);
                                if (w_occ != OCC_W'(1)) begin
                                    n_out_last = 1'b0;
                                    n_state    = ST_DRAIN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                // pop one waiter per free output slot
                if (w_out_free) begin
                    w_qctrl.pop   = 1'b1;
                    n_out_valid   = 1'b1;
                    n_out_block   = 1'b0;
                    n_out_wvalid  = 1'b1;
                    n_out_wthread = ID_W'(w_head_id);
                    n_out_ovf     = 1'b0;
                    n_out_sat     = 1'b0;
                    n_out_last    = (w_occ == OCC_W'(1));
                    if (w_occ == OCC_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A configuration write loads the starting count
        if (i_cfg_wr_en) begin
            n_count = COUNT_W'($unsigned(i_cfg_wr_data));
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_block   <= n_out_block;
        r_out_wvalid  <= n_out_wvalid;
        r_out_wthread <= n_out_wthread;
        r_out_ovf     <= n_out_ovf;
        r_out_sat     <= n_out_sat;
        r_out_last    <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_sat, r_out_ovf, r_out_wthread, r_out_block};
    assign m_axis_tuser  = r_out_wvalid;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

FILE: hw/rtl/csw_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csw_cell
// One slot of the wait queue: loads a new waiter or takes its neighbor's.
// ----------------------------------------------------------------------------
module csw_cell #(
    parameter int ID_BITS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_load,
    input  wire logic               i_shift,
    input  wire logic [ID_BITS-1:0] i_load_id,
    input  wire logic [ID_BITS-1:0] i_next_id,
    output logic      [ID_BITS-1:0] o_id
);

    logic [ID_BITS-1:0] r_id;

    // Take a pushed waiter, or advance toward the head on a pop
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_id <= i_load_id;
        end else if (i_shift) begin
            r_id <= i_next_id;
        end
    end

    assign o_id = r_id;

endmodule
`default_nettype wire

FILE: hw/rtl/csw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csw_queue
// First-in first-out wait queue as a row of cells; the head sits in cell 0.
// ----------------------------------------------------------------------------
module csw_queue #(
    parameter int MAX_WAITERS = 16,
    parameter int ID_BITS     = 8,
    parameter int OCC_W       = $clog2(MAX_WAITERS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  csw_pkg::t_q_ctrl        i_ctrl,
    input  wire logic [ID_BITS-1:0] i_push_id,
    output logic      [ID_BITS-1:0] o_head_id,
    output logic      [OCC_W-1:0]   o_occ
);
    import csw_pkg::*;

    logic [OCC_W-1:0]   r_occ;
    logic [OCC_W-1:0]   n_occ;
    logic [ID_BITS-1:0] w_id [MAX_WAITERS];

    // Build the chain; a pop moves every cell one place toward the head
    for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
        logic [ID_BITS-1:0] w_next;
        if (i < MAX_WAITERS - 1) begin : g_mid
            assign w_next = w_id[i+1];
        end else begin : g_end
            assign w_next = w_id[i];
        end
        csw_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_load    (i_ctrl.push && (r_occ == OCC_W'(i))),
            .i_shift   (i_ctrl.pop),
            .i_load_id (i_push_id),
            .i_next_id (w_next),
            .o_id      (w_id[i])
        );
    end

    // Track how many cells hold a waiter
    always_comb begin
        n_occ = r_occ;
        if (i_ctrl.push) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (i_ctrl.pop) begin
            n_occ = r_occ - OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_head_id = w_id[0];
    assign o_occ     = r_occ;

endmodule
`default_nettype wire
